### rtl/cse_pkg.sv
// ----------------------------------------------------------------------------
// cse_pkg
// Shared opcodes, decoded-instruction types and queue entry layout for the
// 6502 subset execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package cse_pkg;

	// opcode bytes of the implemented subset
	localparam logic [7:0] OPC_BPL     = 8'h10;
	localparam logic [7:0] OPC_CLC     = 8'h18;
	localparam logic [7:0] OPC_AND     = 8'h25;
	localparam logic [7:0] OPC_ROL     = 8'h26;
	localparam logic [7:0] OPC_EOR     = 8'h45;
	localparam logic [7:0] OPC_LSR_A   = 8'h4A;
	localparam logic [7:0] OPC_JMP     = 8'h4C;
	localparam logic [7:0] OPC_ADC     = 8'h69;
	localparam logic [7:0] OPC_SEI     = 8'h78;
	localparam logic [7:0] OPC_STA_ZP  = 8'h85;
	localparam logic [7:0] OPC_STA_ABS = 8'h8D;
	localparam logic [7:0] OPC_STX_ZP  = 8'h86;
	localparam logic [7:0] OPC_STX_ABS = 8'h8E;
	localparam logic [7:0] OPC_STY     = 8'h8C;
	localparam logic [7:0] OPC_DEY     = 8'h88;
	localparam logic [7:0] OPC_TXA     = 8'h8A;
	localparam logic [7:0] OPC_TXS     = 8'h9A;
	localparam logic [7:0] OPC_LDY_IMM = 8'hA0;
	localparam logic [7:0] OPC_LDY_ABS = 8'hAC;
	localparam logic [7:0] OPC_LDX     = 8'hA2;
	localparam logic [7:0] OPC_LDA_ZP  = 8'hA5;
	localparam logic [7:0] OPC_LDA_IMM = 8'hA9;
	localparam logic [7:0] OPC_LDA_ABS = 8'hAD;
	localparam logic [7:0] OPC_LDA_IY  = 8'hB1;
	localparam logic [7:0] OPC_LDA_AX  = 8'hBD;
	localparam logic [7:0] OPC_TAY     = 8'hA8;
	localparam logic [7:0] OPC_TAX     = 8'hAA;
	localparam logic [7:0] OPC_BCS     = 8'hB0;
	localparam logic [7:0] OPC_CMP_ZP  = 8'hC5;
	localparam logic [7:0] OPC_CMP_IMM = 8'hC9;
	localparam logic [7:0] OPC_DEC     = 8'hC6;
	localparam logic [7:0] OPC_INY     = 8'hC8;
	localparam logic [7:0] OPC_DEX     = 8'hCA;
	localparam logic [7:0] OPC_BNE     = 8'hD0;
	localparam logic [7:0] OPC_CLD     = 8'hD8;
	localparam logic [7:0] OPC_CPX     = 8'hE0;
	localparam logic [7:0] OPC_INC     = 8'hE6;
	localparam logic [7:0] OPC_INX     = 8'hE8;
	localparam logic [7:0] OPC_BEQ     = 8'hF0;

	// operation class after decode
	typedef enum logic [4:0] {
		K_BAD, K_BRANCH, K_CLC, K_SEI, K_CLD, K_AND, K_EOR, K_ROL, K_LSR,
		K_JMP, K_ADC, K_STA, K_STX, K_STY, K_DEY, K_INY, K_DEX, K_INX,
		K_TXA, K_TAX, K_TAY, K_TXS, K_LDY, K_LDX, K_LDA, K_CMP, K_CPX,
		K_DEC, K_INC
	} op_kind_t;

	// branch condition
	typedef enum logic [1:0] {
		BR_PL, BR_NE, BR_EQ, BR_CS
	} br_cond_t;

	typedef struct packed {
		op_kind_t kind;
		br_cond_t cond;
	} dec_t;

	// one decoded instruction waiting for the back end
	typedef struct packed {
		dec_t        dec;
		logic [7:0]  operand;
		logic [15:0] next_pc;
		logic [15:0] target;
	} entry_t;

endpackage

`default_nettype wire

### rtl/cse_decode.sv
// ----------------------------------------------------------------------------
// cse_decode
// Front end: classify the opcode byte into an operation class and a branch
// condition.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_decode (
	input  wire logic [7:0]    opcode,
	output cse_pkg::dec_t      dec
);

	// map opcode to class; anything unlisted is flagged bad
	always_comb begin
		dec.kind = cse_pkg::K_BAD;
		dec.cond = cse_pkg::BR_PL;
		unique case (opcode) inside
			cse_pkg::OPC_BPL: begin
				dec.kind = cse_pkg::K_BRANCH;
				dec.cond = cse_pkg::BR_PL;
			end
			cse_pkg::OPC_BNE: begin
				dec.kind = cse_pkg::K_BRANCH;
				dec.cond = cse_pkg::BR_NE;
			end
			cse_pkg::OPC_BEQ: begin
				dec.kind = cse_pkg::K_BRANCH;
				dec.cond = cse_pkg::BR_EQ;
			end
			cse_pkg::OPC_BCS: begin
				dec.kind = cse_pkg::K_BRANCH;
				dec.cond = cse_pkg::BR_CS;
			end
			cse_pkg::OPC_CLC:   dec.kind = cse_pkg::K_CLC;
			cse_pkg::OPC_SEI:   dec.kind = cse_pkg::K_SEI;
			cse_pkg::OPC_CLD:   dec.kind = cse_pkg::K_CLD;
			cse_pkg::OPC_AND:   dec.kind = cse_pkg::K_AND;
			cse_pkg::OPC_EOR:   dec.kind = cse_pkg::K_EOR;
			cse_pkg::OPC_ROL:   dec.kind = cse_pkg::K_ROL;
			cse_pkg::OPC_LSR_A: dec.kind = cse_pkg::K_LSR;
			cse_pkg::OPC_JMP:   dec.kind = cse_pkg::K_JMP;
			cse_pkg::OPC_ADC:   dec.kind = cse_pkg::K_ADC;
			cse_pkg::OPC_STA_ZP, cse_pkg::OPC_STA_ABS: dec.kind = cse_pkg::K_STA;
			cse_pkg::OPC_STX_ZP, cse_pkg::OPC_STX_ABS: dec.kind = cse_pkg::K_STX;
			cse_pkg::OPC_STY:   dec.kind = cse_pkg::K_STY;
			cse_pkg::OPC_DEY:   dec.kind = cse_pkg::K_DEY;
			cse_pkg::OPC_INY:   dec.kind = cse_pkg::K_INY;
			cse_pkg::OPC_DEX:   dec.kind = cse_pkg::K_DEX;
			cse_pkg::OPC_INX:   dec.kind = cse_pkg::K_INX;
			cse_pkg::OPC_TXA:   dec.kind = cse_pkg::K_TXA;
			cse_pkg::OPC_TAX:   dec.kind = cse_pkg::K_TAX;
			cse_pkg::OPC_TAY:   dec.kind = cse_pkg::K_TAY;
			cse_pkg::OPC_TXS:   dec.kind = cse_pkg::K_TXS;
			cse_pkg::OPC_LDY_IMM, cse_pkg::OPC_LDY_ABS: dec.kind = cse_pkg::K_LDY;
			cse_pkg::OPC_LDX:   dec.kind = cse_pkg::K_LDX;
			cse_pkg::OPC_LDA_ZP, cse_pkg::OPC_LDA_IMM, cse_pkg::OPC_LDA_ABS,
			cse_pkg::OPC_LDA_IY, cse_pkg::OPC_LDA_AX: dec.kind = cse_pkg::K_LDA;
			cse_pkg::OPC_CMP_ZP, cse_pkg::OPC_CMP_IMM: dec.kind = cse_pkg::K_CMP;
			cse_pkg::OPC_CPX:   dec.kind = cse_pkg::K_CPX;
			cse_pkg::OPC_DEC:   dec.kind = cse_pkg::K_DEC;
			cse_pkg::OPC_INC:   dec.kind = cse_pkg::K_INC;
			default:            dec.kind = cse_pkg::K_BAD;
		endcase
	end

endmodule

`default_nettype wire

### rtl/cse_queue.sv
// ----------------------------------------------------------------------------
// cse_queue
// Short FIFO of decoded instructions between the front and back ends;
// push and pop may happen in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_queue #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire cse_pkg::entry_t push_data,
	input  wire logic            pop,
	output logic                 full,
	output logic                 empty,
	output cse_pkg::entry_t      head
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	cse_pkg::entry_t   mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == CNT_W'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	// write the entry at the tail
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/cse_execute.sv
// ----------------------------------------------------------------------------
// cse_execute
// Back end: holds A, X, Y, SP and status, runs one decoded instruction
// per cycle unless stalled and registers the result for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module cse_execute (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head_valid,
	input  wire cse_pkg::entry_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_stall,
	output logic [15:0]          new_pc,
	output logic                 store_enable,
	output logic [7:0]           store_byte,
	output logic [7:0]           status_out,
	output logic [7:0]           acc_out,
	output logic [7:0]           xreg_out,
	output logic [7:0]           yreg_out,
	output logic [7:0]           sp_out,
	output logic [1:0]           extra_cycles,
	output logic                 bad_opcode
);

	localparam int FLAG_C = 0;
	localparam int FLAG_Z = 1;
	localparam int FLAG_I = 2;
	localparam int FLAG_D = 3;
	localparam int FLAG_U = 5;
	localparam int FLAG_V = 6;
	localparam int FLAG_N = 7;
	localparam logic [7:0] SP_RESET = 8'hFD;

	// set N and Z from a result byte
	function automatic logic [7:0] with_nz(input logic [7:0] st, input logic [7:0] v);
		logic [7:0] r;
		r         = st;
		r[FLAG_Z] = (v == 8'h00);
		r[FLAG_N] = v[7];
		return r;
	endfunction

	// architectural state
	logic [7:0] acc_q, x_q, y_q, sp_q, st_q;

	// output register
	logic        out_valid_q;
	logic [15:0] pc_q;
	logic        st_en_q;
	logic [7:0]  st_byte_q;
	logic [1:0]  extra_q;
	logic        bad_q;

	// next-state values
	logic [7:0]  a_n, x_n, y_n, sp_n, st_n;
	logic [15:0] pc_n;
	logic        st_en_n;
	logic [7:0]  st_byte_n;
	logic [1:0]  extra_n;
	logic        bad_n;
	logic        take;
	logic [8:0]  adc_sum;
	logic [7:0]  cmp_lhs;
	logic [8:0]  cmp_diff;
	logic [15:0] br_dest;
	logic [7:0]  m;

	assign m   = head.operand;
	assign pop = head_valid && (!out_valid_q || !out_stall);

	// ADC adder and the comparator shared by CMP and CPX
	assign adc_sum  = {1'b0, acc_q} + {1'b0, m} + {8'h00, st_q[FLAG_C]};
	assign cmp_lhs  = (head.dec.kind == cse_pkg::K_CPX) ? x_q : acc_q;
	assign cmp_diff = {1'b0, cmp_lhs} - {1'b0, m};
	assign br_dest  = head.next_pc + {{8{m[7]}}, m};

	// branch condition
	always_comb begin
		case (head.dec.cond)
			cse_pkg::BR_PL: take = !st_q[FLAG_N];
			cse_pkg::BR_NE: take = !st_q[FLAG_Z];
			cse_pkg::BR_EQ: take = st_q[FLAG_Z];
			cse_pkg::BR_CS: take = st_q[FLAG_C];
			default:        take = 1'b0;
		endcase
	end

	// execute one instruction
	always_comb begin
		a_n       = acc_q;
		x_n       = x_q;
		y_n       = y_q;
		sp_n      = sp_q;
		st_n      = st_q;
		pc_n      = head.next_pc;
		st_en_n   = 1'b0;
		st_byte_n = 8'h00;
		extra_n   = 2'd0;
		bad_n     = 1'b0;
		unique case (head.dec.kind) inside
			cse_pkg::K_BRANCH: begin
				if (take) begin
					pc_n    = br_dest;
					extra_n = (br_dest[15:8] != head.next_pc[15:8]) ? 2'd2 : 2'd1;
				end
			end
			cse_pkg::K_CLC: st_n[FLAG_C] = 1'b0;
			cse_pkg::K_SEI: st_n[FLAG_I] = 1'b1;
			cse_pkg::K_CLD: st_n[FLAG_D] = 1'b0;
			cse_pkg::K_AND: begin
				a_n  = acc_q & m;
				st_n = with_nz(st_q, acc_q & m);
			end
			cse_pkg::K_EOR: begin
				a_n  = acc_q ^ m;
				st_n = with_nz(st_q, acc_q ^ m);
			end
			cse_pkg::K_ROL: begin
				st_byte_n    = {m[6:0], st_q[FLAG_C]};
				st_en_n      = 1'b1;
				st_n         = with_nz(st_q, {m[6:0], st_q[FLAG_C]});
				st_n[FLAG_C] = m[7];
			end
			cse_pkg::K_LSR: begin
				a_n          = {1'b0, acc_q[7:1]};
				st_n         = with_nz(st_q, {1'b0, acc_q[7:1]});
				st_n[FLAG_C] = acc_q[0];
			end
			cse_pkg::K_JMP: pc_n = head.target;
			cse_pkg::K_ADC: begin
				a_n          = adc_sum[7:0];
				st_n         = with_nz(st_q, adc_sum[7:0]);
				st_n[FLAG_C] = adc_sum[8];
				st_n[FLAG_V] = ~(acc_q[7] ^ m[7]) & (acc_q[7] ^ adc_sum[7]);
			end
			cse_pkg::K_STA: begin
				st_en_n   = 1'b1;
				st_byte_n = acc_q;
			end
			cse_pkg::K_STX: begin
				st_en_n   = 1'b1;
				st_byte_n = x_q;
			end
			cse_pkg::K_STY: begin
				st_en_n   = 1'b1;
				st_byte_n = y_q;
			end
			cse_pkg::K_DEY: begin
				y_n  = y_q - 8'd1;
				st_n = with_nz(st_q, y_q - 8'd1);
			end
			cse_pkg::K_INY: begin
				y_n  = y_q + 8'd1;
				st_n = with_nz(st_q, y_q + 8'd1);
			end
			cse_pkg::K_DEX: begin
				x_n  = x_q - 8'd1;
				st_n = with_nz(st_q, x_q - 8'd1);
			end
			cse_pkg::K_INX: begin
				x_n  = x_q + 8'd1;
				st_n = with_nz(st_q, x_q + 8'd1);
			end
			cse_pkg::K_TXA: begin
				a_n  = x_q;
				st_n = with_nz(st_q, x_q);
			end
			cse_pkg::K_TAX: begin
				x_n  = acc_q;
				st_n = with_nz(st_q, acc_q);
			end
			cse_pkg::K_TAY: begin
				y_n  = acc_q;
				st_n = with_nz(st_q, acc_q);
			end
			cse_pkg::K_TXS: sp_n = x_q;
			cse_pkg::K_LDY: begin
				y_n  = m;
				st_n = with_nz(st_q, m);
			end
			cse_pkg::K_LDX: begin
				x_n  = m;
				st_n = with_nz(st_q, m);
			end
			cse_pkg::K_LDA: begin
				a_n  = m;
				st_n = with_nz(st_q, m);
			end
			cse_pkg::K_CMP, cse_pkg::K_CPX: begin
				st_n         = with_nz(st_q, cmp_diff[7:0]);
				st_n[FLAG_C] = !cmp_diff[8];
			end
			cse_pkg::K_DEC: begin
				st_en_n   = 1'b1;
				st_byte_n = m - 8'd1;
				st_n      = with_nz(st_q, m - 8'd1);
			end
			cse_pkg::K_INC: begin
				st_en_n   = 1'b1;
				st_byte_n = m + 8'd1;
				st_n      = with_nz(st_q, m + 8'd1);
			end
			default: bad_n = 1'b1;
		endcase
		// force bit 5 on every executed instruction
		if (!bad_n) begin
			st_n[FLAG_U] = 1'b1;
		end
	end

	// commit state and load the output register on each pop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= 8'h00;
			x_q         <= 8'h00;
			y_q         <= 8'h00;
			sp_q        <= SP_RESET;
			st_q        <= 8'h00;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				acc_q       <= a_n;
				x_q         <= x_n;
				y_q         <= y_n;
				sp_q        <= sp_n;
				st_q        <= st_n;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload; held while stalled
	always_ff @(posedge clk) begin
		if (pop) begin
			pc_q      <= pc_n;
			st_en_q   <= st_en_n;
			st_byte_q <= st_byte_n;
			extra_q   <= extra_n;
			bad_q     <= bad_n;
		end
	end

	assign out_valid    = out_valid_q;
	assign new_pc       = pc_q;
	assign store_enable = st_en_q;
	assign store_byte   = st_byte_q;
	assign status_out   = st_q;
	assign acc_out      = acc_q;
	assign xreg_out     = x_q;
	assign yreg_out     = y_q;
	assign sp_out       = sp_q;
	assign extra_cycles = extra_q;
	assign bad_opcode   = bad_q;

endmodule

`default_nettype wire

### rtl/cpu6502_subset_execute_unit.sv
// ----------------------------------------------------------------------------
// cpu6502_subset_execute_unit
// Execute stage for a subset of the 6502: decode front end, instruction
// queue and ALU/flag back end.
// ----------------------------------------------------------------------------
// The unit executes one already-fetched instruction per clock at sustained
// rate while the output is not stalled. An accepted instruction is decoded
// and written into a short queue on the accept edge, executed by the back
// end when it reaches the queue head, and its result is loaded into the
// output registers when the back end pops it, which waits while the output
// is stalled. The back end keeps A, X, Y, SP and status and updates them at
// each pop; that ALU and flag update sets the rate, and the queue holds
// QUEUE_DEPTH instructions, plus one result in the output register, before
// the input stalls. Unlisted opcodes are reported with bad_opcode set and
// leave all state unchanged.
`default_nettype none

module cpu6502_subset_execute_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [7:0]   opcode,
	input  wire logic [7:0]   operand,
	input  wire logic [15:0]  next_pc,
	input  wire logic [15:0]  target,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [15:0]       new_pc,
	output logic              store_enable,
	output logic [7:0]        store_byte,
	output logic [7:0]        status_out,
	output logic [7:0]        acc_out,
	output logic [7:0]        xreg_out,
	output logic [7:0]        yreg_out,
	output logic [7:0]        sp_out,
	output logic [1:0]        extra_cycles,
	output logic              bad_opcode
);

	cse_pkg::dec_t   dec;
	cse_pkg::entry_t push_data;
	cse_pkg::entry_t head;
	logic            q_full;
	logic            q_empty;
	logic            pop;
	logic            push;

	// classify incoming opcode
	cse_decode u_decode (
		.opcode (opcode),
		.dec    (dec)
	);

	// bundle the decoded instruction
	always_comb begin
		push_data.dec     = dec;
		push_data.operand = operand;
		push_data.next_pc = next_pc;
		push_data.target  = target;
	end

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	cse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.full      (q_full),
		.empty     (q_empty),
		.head      (head)
	);

	cse_execute u_execute (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (!q_empty),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.new_pc       (new_pc),
		.store_enable (store_enable),
		.store_byte   (store_byte),
		.status_out   (status_out),
		.acc_out      (acc_out),
		.xreg_out     (xreg_out),
		.yreg_out     (yreg_out),
		.sp_out       (sp_out),
		.extra_cycles (extra_cycles),
		.bad_opcode   (bad_opcode)
	);

endmodule

`default_nettype wire
